FILE: rtl/tlvb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlvb_pkg;

	// request action codes
	localparam logic [2:0] ACT_CLEAR    = 3'd0;
	localparam logic [2:0] ACT_HEADER   = 3'd1;
	localparam logic [2:0] ACT_PAYLOAD  = 3'd2;
	localparam logic [2:0] ACT_SCALAR   = 3'd3;
	localparam logic [2:0] ACT_FINALIZE = 3'd4;
	localparam logic [2:0] ACT_FIND     = 3'd5;
	localparam logic [2:0] ACT_READ     = 3'd6;

	// scalar sizes in bytes; zero means a plain find
	localparam logic [3:0] SIZE_PLAIN = 4'd0;
	localparam logic [3:0] SIZE_WORD  = 4'd4;
	localparam logic [3:0] SIZE_DWORD = 4'd8;

	localparam logic [3:0] HDR_BYTES = 4'd4;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_HDR_CHK,
		ST_FETCH,
		ST_HDR_EVAL,
		ST_PAY_EVAL,
		ST_READ_EVAL,
		ST_DONE
	} tlvb_state_t;

	// what a byte fetch feeds once it completes
	typedef enum logic [1:0] {
		FM_HDR,
		FM_PAY,
		FM_READ
	} tlvb_fetch_t;

endpackage

`default_nettype wire

FILE: rtl/tlvb_store.sv
`timescale 1ns / 1ps
`default_nettype none

module tlvb_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/tlv_record_builder_walker.sv
// Channel   Direction  Handshake              Carries
// input     in         in_valid / in_stall    action, tag, length, data_byte, value,
//                                             scalar_size, address
// output    out        out_valid / out_stall  status, payload_offset, payload_length,
//                                             found_value, blob_length, read_data
// config    in         cfg_valid / cfg_ready  cfg_data = capacity (13 bits)
//
// One request at a time; the byte store has one write and one read port.
// A rejected request goes straight to the result; find reads each header in turn
// and, for a scalar, then fetches that record's payload to decode it.
// The input side is stalled from acceptance until the result is moved into the
// output register; a waiting result does not block the next request.
// arst_n clears fill length, seal, owed count, capacity (4096) and handshakes;
// the store itself is not cleared: only bytes below the fill length are read.
`timescale 1ns / 1ps
`default_nettype none

module tlv_record_builder_walker import tlvb_pkg::*; #(
	parameter int          STORE_BYTES = 4096,
	parameter logic [15:0] END_TAG     = 16'h0000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] tag,
	input  wire logic [15:0] length,
	input  wire logic [7:0]  data_byte,
	input  wire logic [63:0] value,
	input  wire logic [3:0]  scalar_size,
	input  wire logic [11:0] address,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic      [12:0] payload_offset,
	output logic      [15:0] payload_length,
	output logic      [63:0] found_value,
	output logic      [12:0] blob_length,
	output logic      [7:0]  read_data,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [12:0] cfg_data
);

	localparam int          AW        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

	// architectural state
	logic [12:0] capacity_q;
	logic [12:0] fill_q;
	logic        sealed_q;
	logic [15:0] owed_q;

	// sequencer
	tlvb_state_t state_q, state_d;
	tlvb_fetch_t fmode_q;
	logic [15:0] tag_q;
	logic [3:0]  size_q;

	// byte writer: little-endian shift buffer, up to header + 8 bytes
	logic [95:0] wbuf_q;
	logic [3:0]  wcnt_q;

	// byte fetcher and walk pointer
	logic [17:0] off_q;
	logic [17:0] base_q;
	logic [3:0]  need_q;
	logic [3:0]  issue_q;
	logic [3:0]  recv_q;
	logic        rd_s1;
	logic        inr_s1;
	logic [63:0] acc_q;

	// result under construction
	logic        res_status_q;
	logic [12:0] res_off_q;
	logic [15:0] res_len_q;
	logic [63:0] res_val_q;
	logic [7:0]  res_rd_q;

	logic        out_valid_q;

	// combinational
	logic        in_acc;
	logic        out_free;
	logic [16:0] cap_lim;
	logic [17:0] fill_ext;
	logic [17:0] cap_ext;
	logic        room_hdr;
	logic        room_sc;
	logic        room_fin;
	logic        size_ok_sc;
	logic        size_ok_find;
	logic        can_emit;
	logic [15:0] hdr_id;
	logic [15:0] hdr_len;
	logic        issue;
	logic [17:0] fetch_addr;
	logic        fetch_inr;
	logic        fetch_last;
	logic        mem_we;
	logic [7:0]  mem_rdata;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// effective capacity is the smaller of the register and the store
	assign cap_lim  = ({4'b0, capacity_q} < STORE_LIM) ? {4'b0, capacity_q} : STORE_LIM;
	assign fill_ext = {5'b0, fill_q};
	assign cap_ext  = {1'b0, cap_lim};

	assign room_hdr = (fill_ext + 18'd4 + {2'b0, length}) <= cap_ext;
	assign room_sc  = (fill_ext + 18'd4 + {14'b0, scalar_size}) <= cap_ext;
	assign room_fin = (fill_ext + 18'd4) <= cap_ext;

	assign size_ok_sc   = (scalar_size == SIZE_WORD) || (scalar_size == SIZE_DWORD);
	assign size_ok_find = size_ok_sc || (scalar_size == SIZE_PLAIN);
	assign can_emit     = !sealed_q && (owed_q == 16'd0);

	// header bytes land in the top half of the accumulator
	assign hdr_id  = acc_q[47:32];
	assign hdr_len = acc_q[63:48];

	// fetch address generator; bytes at or past the fill length read as zero
	assign issue      = (state_q == ST_FETCH) && (issue_q < need_q);
	assign fetch_addr = base_q + {14'b0, issue_q};
	assign fetch_inr  = fetch_addr < fill_ext;
	assign fetch_last = rd_s1 && (recv_q == (need_q - 4'd1));

	assign mem_we = (state_q == ST_WRITE);

	tlvb_store #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(fill_q)),
		.wdata (wbuf_q[7:0]),
		.raddr (fetch_addr[AW-1:0]),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (action)
						ACT_CLEAR:    state_d = ST_DONE;
						ACT_HEADER:   state_d = (can_emit && room_hdr) ? ST_WRITE : ST_DONE;
						ACT_PAYLOAD:  state_d = (owed_q != 16'd0) ? ST_WRITE : ST_DONE;
						ACT_SCALAR:   state_d = (can_emit && size_ok_sc && room_sc) ?
						                        ST_WRITE : ST_DONE;
						ACT_FINALIZE: state_d = (can_emit && room_fin) ? ST_WRITE : ST_DONE;
						ACT_FIND:     state_d = (sealed_q && size_ok_find) ? ST_HDR_CHK : ST_DONE;
						ACT_READ:     state_d = ({6'b0, address} < fill_ext) ? ST_FETCH : ST_DONE;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			ST_WRITE: begin
				if (wcnt_q == 4'd1) begin
					state_d = ST_DONE;
				end
			end
			ST_HDR_CHK: begin
				state_d = ((off_q + 18'd4) <= fill_ext) ? ST_FETCH : ST_DONE;
			end
			ST_FETCH: begin
				if (fetch_last) begin
					case (fmode_q)
						FM_HDR:  state_d = ST_HDR_EVAL;
						FM_PAY:  state_d = ST_PAY_EVAL;
						FM_READ: state_d = ST_READ_EVAL;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_HDR_EVAL: begin
				if (hdr_id == END_TAG) begin
					state_d = ST_DONE;
				end else if (hdr_id == tag_q) begin
					if (size_q != SIZE_PLAIN && hdr_len == {12'b0, size_q}) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_HDR_CHK;
				end
			end
			ST_PAY_EVAL:  state_d = ST_DONE;
			ST_READ_EVAL: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= 13'd4096;
			fill_q      <= 13'd0;
			sealed_q    <= 1'b0;
			owed_q      <= 16'd0;
			out_valid_q <= 1'b0;
			rd_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= issue;

			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end

			if (state_q == ST_IDLE && in_acc) begin
				case (action)
					ACT_CLEAR: begin
						fill_q   <= 13'd0;
						sealed_q <= 1'b0;
						owed_q   <= 16'd0;
					end
					ACT_HEADER: begin
						if (can_emit && room_hdr) begin
							owed_q <= length;
						end
					end
					ACT_PAYLOAD: begin
						if (owed_q != 16'd0) begin
							owed_q <= owed_q - 16'd1;
						end
					end
					ACT_FINALIZE: begin
						if (can_emit && room_fin) begin
							sealed_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (state_q == ST_WRITE) begin
				fill_q <= fill_q + 13'd1;
			end

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (issue) begin
			issue_q <= issue_q + 4'd1;
		end
		inr_s1 <= fetch_inr;
		if (rd_s1) begin
			acc_q  <= {(inr_s1 ? mem_rdata : 8'h00), acc_q[63:8]};
			recv_q <= recv_q + 4'd1;
		end

		case (state_q)
			ST_IDLE: begin
				res_status_q <= STATUS_FAIL;
				res_off_q    <= 13'd0;
				res_len_q    <= 16'd0;
				res_val_q    <= 64'd0;
				res_rd_q     <= 8'd0;
				tag_q        <= tag;
				size_q       <= scalar_size;
				off_q        <= 18'd0;
				issue_q      <= 4'd0;
				recv_q       <= 4'd0;
				base_q       <= {6'b0, address};
				need_q       <= 4'd1;
				fmode_q      <= FM_READ;
				case (action)
					ACT_CLEAR: begin
						res_status_q <= STATUS_OK;
					end
					ACT_HEADER: begin
						wbuf_q <= {64'd0, length, tag};
						wcnt_q <= HDR_BYTES;
						if (can_emit && room_hdr) begin
							res_status_q <= STATUS_OK;
						end
					end
					ACT_PAYLOAD: begin
						wbuf_q <= {88'd0, data_byte};
						wcnt_q <= 4'd1;
						if (owed_q != 16'd0) begin
							res_status_q <= STATUS_OK;
						end
					end
					ACT_SCALAR: begin
						wbuf_q <= {value, 12'd0, scalar_size, tag};
						wcnt_q <= HDR_BYTES + scalar_size;
						if (can_emit && size_ok_sc && room_sc) begin
							res_status_q <= STATUS_OK;
						end
					end
					ACT_FINALIZE: begin
						wbuf_q <= {80'd0, END_TAG};
						wcnt_q <= HDR_BYTES;
						if (sealed_q || (can_emit && room_fin)) begin
							res_status_q <= STATUS_OK;
						end
					end
					default: ;
				endcase
			end
			ST_WRITE: begin
				wbuf_q <= {8'd0, wbuf_q[95:8]};
				wcnt_q <= wcnt_q - 4'd1;
			end
			ST_HDR_CHK: begin
				base_q  <= off_q;
				need_q  <= HDR_BYTES;
				fmode_q <= FM_HDR;
				issue_q <= 4'd0;
				recv_q  <= 4'd0;
			end
			ST_HDR_EVAL: begin
				if (hdr_id != END_TAG && hdr_id == tag_q) begin
					if (size_q == SIZE_PLAIN) begin
						res_status_q <= STATUS_OK;
						res_off_q    <= 13'(off_q + 18'd4);
						res_len_q    <= hdr_len;
					end
					base_q  <= off_q + 18'd4;
					need_q  <= size_q;
					fmode_q <= FM_PAY;
					issue_q <= 4'd0;
					recv_q  <= 4'd0;
				end else begin
					off_q <= off_q + 18'd4 + {2'b0, hdr_len};
				end
			end
			ST_PAY_EVAL: begin
				res_status_q <= STATUS_OK;
				res_off_q    <= 13'(off_q + 18'd4);
				res_len_q    <= {12'd0, size_q};
				res_val_q    <= (size_q == SIZE_WORD) ? {32'd0, acc_q[63:32]} : acc_q;
			end
			ST_READ_EVAL: begin
				res_status_q <= STATUS_OK;
				res_rd_q     <= acc_q[63:56];
			end
			default: ;
		endcase

		// output register
		if (state_q == ST_DONE && out_free) begin
			status         <= res_status_q;
			payload_offset <= res_off_q;
			payload_length <= res_len_q;
			found_value    <= res_val_q;
			blob_length    <= fill_q;
			read_data      <= res_rd_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tlvb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tlvb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        status,
	input wire logic [12:0] payload_offset,
	input wire logic [15:0] payload_length,
	input wire logic [63:0] found_value,
	input wire logic [12:0] blob_length,
	input wire logic [7:0]  read_data
);

	// a request keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a failed request reports no find or read data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> payload_offset == 13'd0 && payload_length == 16'd0 &&
		found_value == 64'd0 && read_data == 8'd0)
		else $error("failed request carries data");

	// a found payload starts past its header and inside the blob
	a_offset_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && payload_offset != 13'd0 |->
		payload_offset >= 13'd4 && payload_offset <= blob_length)
		else $error("payload offset outside blob");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(blob_length) && $stable(found_value))
		else $error("stalled result changed");

endmodule

bind tlv_record_builder_walker tlvb_checker u_tlvb_checker (.*);

`default_nettype wire

FILE: tb/sv/tlvb_book_pkg.sv
`timescale 1ns / 1ps

package tlvb_book_pkg;
	import tlvb_pkg::*;

	localparam int          STORE_SIZE = 4096;
	localparam logic [15:0] TERM_TAG   = 16'h0000;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] tag;
		logic [15:0] length;
		logic [7:0]  data_byte;
		logic [63:0] value;
		logic [3:0]  scalar_size;
		logic [11:0] address;
	} tlv_request_t;

	typedef struct packed {
		logic        status;
		logic [12:0] payload_offset;
		logic [15:0] payload_length;
		logic [63:0] found_value;
		logic [12:0] blob_length;
		logic [7:0]  read_data;
	} tlv_reply_t;

	// Shadow copy of the record store plus the queue of replies still owed by the block.
	class blob_book;
		logic [7:0]  mem [STORE_SIZE];
		int unsigned fill;
		int unsigned owed;
		int unsigned cap_bytes;
		bit          sealed;
		tlv_reply_t  replies_due[$];
		int          requests;
		int          errors;
		int          find_hits;
		int          read_hits;

		function new();
			fill = 0;
			owed = 0;
			cap_bytes = 4096;
			sealed = 0;
			requests = 0;
			errors = 0;
			find_hits = 0;
			read_hits = 0;
		endfunction

		function int unsigned peek(int unsigned at);
			if (at >= fill || at >= STORE_SIZE)
				return 0;
			return mem[at];
		endfunction

		function void push_byte(logic [7:0] b);
			if (fill < STORE_SIZE)
				mem[fill] = b;
			fill++;
		endfunction

		// header write: fails when sealed, mid-payload, or out of room
		function bit open_record(logic [15:0] t, int unsigned len);
			int unsigned lim;
			lim = (cap_bytes < STORE_SIZE) ? cap_bytes : STORE_SIZE;
			if (sealed || owed != 0 || fill + 4 + len > lim)
				return 0;
			push_byte(t[7:0]);
			push_byte(t[15:8]);
			push_byte(len[7:0]);
			push_byte(len[15:8]);
			return 1;
		endfunction

		function tlv_reply_t apply_request(tlv_request_t r);
			tlv_reply_t  y;
			int unsigned off;
			int unsigned id;
			int unsigned ln;
			int unsigned n;
			logic [63:0] v;
			y = '0;
			y.status = STATUS_FAIL;
			case (r.action)
				ACT_CLEAR: begin
					fill = 0;
					sealed = 0;
					owed = 0;
					y.status = STATUS_OK;
				end
				ACT_HEADER: begin
					if (open_record(r.tag, r.length)) begin
						owed = r.length;
						y.status = STATUS_OK;
					end
				end
				ACT_PAYLOAD: begin
					if (owed != 0) begin
						push_byte(r.data_byte);
						owed--;
						y.status = STATUS_OK;
					end
				end
				ACT_SCALAR: begin
					if (r.scalar_size == SIZE_WORD || r.scalar_size == SIZE_DWORD) begin
						if (open_record(r.tag, r.scalar_size)) begin
							for (n = 0; n < r.scalar_size; n++)
								push_byte(r.value[8*n +: 8]);
							y.status = STATUS_OK;
						end
					end
				end
				ACT_FINALIZE: begin
					if (sealed) begin
						y.status = STATUS_OK;
					end else if (open_record(TERM_TAG, 0)) begin
						sealed = 1;
						y.status = STATUS_OK;
					end
				end
				ACT_FIND: begin
					if (sealed && (r.scalar_size == SIZE_PLAIN || r.scalar_size == SIZE_WORD
							|| r.scalar_size == SIZE_DWORD)) begin
						off = 0;
						while (off + 4 <= fill) begin
							id = peek(off) | (peek(off + 1) << 8);
							ln = peek(off + 2) | (peek(off + 3) << 8);
							// end marker stops the walk before any tag match
							if (id == TERM_TAG)
								break;
							if (id == r.tag) begin
								if (r.scalar_size == SIZE_PLAIN || ln == r.scalar_size) begin
									v = '0;
									if (r.scalar_size != SIZE_PLAIN)
										for (n = ln; n > 0; n--)
											v = (v << 8) | peek(off + 3 + n);
									y.status = STATUS_OK;
									y.payload_offset = 13'(off + 4);
									y.payload_length = 16'(ln);
									y.found_value = v;
									find_hits++;
								end
								break;
							end
							off += 4 + ln;
						end
					end
				end
				ACT_READ: begin
					if (r.address < fill) begin
						y.read_data = 8'(peek(r.address));
						y.status = STATUS_OK;
						read_hits++;
					end
				end
				default: ;
			endcase
			y.blob_length = 13'(fill);
			return y;
		endfunction

		function void note_request(tlv_request_t r);
			requests++;
			replies_due.push_back(apply_request(r));
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		function void check_reply(tlv_reply_t got);
			tlv_reply_t want;
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: reply with no request outstanding, expected none got status %0h",
					$time, got.status);
				return;
			end
			want = replies_due.pop_front();
			field_check("status", want.status, got.status);
			field_check("payload_offset", want.payload_offset, got.payload_offset);
			field_check("payload_length", want.payload_length, got.payload_length);
			field_check("found_value", want.found_value, got.found_value);
			field_check("blob_length", want.blob_length, got.blob_length);
			field_check("read_data", want.read_data, got.read_data);
		endfunction
	endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tlvb_pkg::*;
	import tlvb_book_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [15:0] tag;
	logic [15:0] length;
	logic [7:0]  data_byte;
	logic [63:0] value;
	logic [3:0]  scalar_size;
	logic [11:0] address;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [12:0] payload_offset;
	logic [15:0] payload_length;
	logic [63:0] found_value;
	logic [12:0] blob_length;
	logic [7:0]  read_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;

	blob_book book;
	int       gap_pct;     // chance per request of an input gap burst
	int       stall_pct;   // chance per cycle of an output stall burst
	int       settings;    // capacity writes done

	tlv_record_builder_walker #(
		.STORE_BYTES(STORE_SIZE),
		.END_TAG(TERM_TAG)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.tag(tag),
		.length(length),
		.data_byte(data_byte),
		.value(value),
		.scalar_size(scalar_size),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.found_value(found_value),
		.blob_length(blob_length),
		.read_data(read_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop; a correct run with both sides' longest bursts on every
	// request needs only a small fraction of this.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Output side: stall in random bursts while enabled.
	initial begin : stall_gen
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every reply moved at an edge is checked against the oldest prediction.
	// Sampling right after the edge sees the values the edge itself saw.
	always @(posedge clk) begin : reply_monitor
		tlv_reply_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.payload_offset = payload_offset;
			got.payload_length = payload_length;
			got.found_value = found_value;
			got.blob_length = blob_length;
			got.read_data = read_data;
			book.check_reply(got);
		end
	end

	// Request with every field random; callers overwrite what matters.
	function automatic tlv_request_t rand_request(logic [2:0] act);
		tlv_request_t r;
		r.action = act;
		r.tag = 16'($urandom);
		r.length = 16'($urandom);
		r.data_byte = 8'($urandom);
		r.value = {$urandom, $urandom};
		r.scalar_size = 4'($urandom);
		r.address = 12'($urandom);
		return r;
	endfunction

	// Present one request and hold it until accepted. A gap first drops valid for
	// a random pause; otherwise valid stays high straight into the next one.
	task automatic send_request(input tlv_request_t r);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.action;
		tag <= r.tag;
		length <= r.length;
		data_byte <= r.data_byte;
		value <= r.value;
		scalar_size <= r.scalar_size;
		address <= r.address;
		do @(posedge clk); while (in_stall);
		book.note_request(r);
	endtask

	// Let every outstanding reply come back; the block is idle after that
	// since each request yields exactly one reply.
	task automatic drain();
		in_valid <= 1'b0;
		while (book.replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [12:0] cap);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.cap_bytes = cap;
		settings++;
	endtask

	// One build/seal/search round. Mostly well formed with random content;
	// a few rounds skip the clear or the seal, cut a payload short, or carry
	// stray requests, so the reject paths get exercised too.
	task automatic blob_round();
		int           n_rec;
		int           i;
		int           k;
		int           n_ask;
		logic [15:0]  t;
		logic [15:0]  tags[$];
		tlv_request_t r;
		if ($urandom_range(0, 9) != 0)
			send_request(rand_request(ACT_CLEAR));
		n_rec = $urandom_range(1, 8);
		for (i = 0; i < n_rec; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_request(rand_request(3'($urandom_range(0, 7))));
			// reuse a tag now and then so a find must return the first match
			if (tags.size() != 0 && $urandom_range(0, 3) == 0)
				t = tags[$urandom_range(0, tags.size() - 1)];
			else if ($urandom_range(0, 11) == 0)
				t = TERM_TAG;
			else
				t = 16'($urandom);
			tags.push_back(t);
			if ($urandom_range(0, 1) == 1) begin
				r = rand_request(ACT_SCALAR);
				r.tag = t;
				if ($urandom_range(0, 9) != 0)
					r.scalar_size = ($urandom_range(0, 1) == 1) ? SIZE_WORD : SIZE_DWORD;
				send_request(r);
			end else begin
				r = rand_request(ACT_HEADER);
				r.tag = t;
				r.length = ($urandom_range(0, 19) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 10));
				send_request(r);
				// payload bytes; long or cut-short payloads leave the blob mid-record
				k = 0;
				while (book.owed != 0 && k < 12 && $urandom_range(0, 29) != 0) begin
					send_request(rand_request(ACT_PAYLOAD));
					k++;
				end
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_request(rand_request(ACT_FINALIZE));
		n_ask = $urandom_range(2, 6);
		for (i = 0; i < n_ask; i++) begin
			r = rand_request(ACT_FIND);
			if ($urandom_range(0, 9) < 7)
				r.tag = tags[$urandom_range(0, tags.size() - 1)];
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: r.scalar_size = SIZE_PLAIN;
				5, 6:          r.scalar_size = SIZE_WORD;
				7, 8:          r.scalar_size = SIZE_DWORD;
				default: ;
			endcase
			send_request(r);
		end
		n_ask = $urandom_range(1, 3);
		for (i = 0; i < n_ask; i++) begin
			r = rand_request(ACT_READ);
			if ($urandom_range(0, 4) != 0)
				r.address = 12'($urandom_range(0, book.fill + 3));
			send_request(r);
		end
	endtask

	// New capacity once idle, then random rounds until the request count is
	// reached. The quiet phase has no gaps and no stalls.
	task automatic run_phase(input logic [12:0] cap, input int count, input bit quiet);
		int target;
		drain();
		write_capacity(cap);
		if (quiet) begin
			gap_pct = 0;
			stall_pct = 0;
		end else begin
			case ($urandom_range(0, 2))
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 15; stall_pct = 10; end
				default: begin gap_pct = 40; stall_pct = 30; end
			endcase
		end
		target = book.requests + count;
		while (book.requests < target)
			blob_round();
	endtask

	initial begin : stimulus
		tlv_request_t r;
		book = new();
		settings = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_CLEAR;
		tag = '0;
		length = '0;
		data_byte = '0;
		value = '0;
		scalar_size = SIZE_PLAIN;
		address = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity.
		r = rand_request(ACT_FIND);            // find before sealing
		r.tag = 16'h1234;
		r.scalar_size = SIZE_PLAIN;
		send_request(r);
		r = rand_request(ACT_PAYLOAD);         // payload byte with none owed
		r.data_byte = 8'hff;
		send_request(r);
		r = rand_request(ACT_HEADER);
		r.tag = 16'h1234;
		r.length = 16'd2;
		send_request(r);
		r = rand_request(ACT_HEADER);          // header while payload owed
		r.tag = 16'h2222;
		r.length = 16'd1;
		send_request(r);
		send_request(rand_request(ACT_FINALIZE));   // seal while payload owed
		r = rand_request(ACT_PAYLOAD);
		r.data_byte = 8'h00;
		send_request(r);
		r = rand_request(ACT_PAYLOAD);
		r.data_byte = 8'hff;
		send_request(r);
		r = rand_request(ACT_SCALAR);
		r.tag = 16'hffff;
		r.scalar_size = SIZE_DWORD;
		r.value = '1;
		send_request(r);
		r = rand_request(ACT_SCALAR);          // upper half of value is dropped
		r.tag = 16'h0001;
		r.scalar_size = SIZE_WORD;
		r.value = 64'h8000_0000_dead_beef;
		send_request(r);
		r = rand_request(ACT_SCALAR);          // illegal scalar size
		r.scalar_size = 4'hf;
		send_request(r);
		r = rand_request(ACT_HEADER);          // no room for the announced payload
		r.tag = 16'h00ff;
		r.length = 16'hffff;
		send_request(r);
		r = rand_request(ACT_HEADER);          // empty payload
		r.tag = 16'hbeef;
		r.length = 16'd0;
		send_request(r);
		send_request(rand_request(3'd7));      // unused action code
		r = rand_request(ACT_SCALAR);          // record tagged with the end marker
		r.tag = TERM_TAG;
		r.scalar_size = SIZE_WORD;
		r.value = '0;
		send_request(r);
		r = rand_request(ACT_SCALAR);          // hidden behind the end marker
		r.tag = 16'h7777;
		r.scalar_size = SIZE_DWORD;
		send_request(r);
		send_request(rand_request(ACT_FINALIZE));
		send_request(rand_request(ACT_FINALIZE));   // already sealed
		r = rand_request(ACT_HEADER);          // emit after sealing
		r.length = 16'd1;
		send_request(r);
		r = rand_request(ACT_FIND);
		r.tag = 16'h1234;
		r.scalar_size = SIZE_PLAIN;
		send_request(r);
		r = rand_request(ACT_FIND);
		r.tag = 16'hffff;
		r.scalar_size = SIZE_DWORD;
		send_request(r);
		r = rand_request(ACT_FIND);            // length differs from asked size
		r.tag = 16'h0001;
		r.scalar_size = SIZE_DWORD;
		send_request(r);
		r = rand_request(ACT_FIND);            // walk stops at the end marker
		r.tag = 16'h7777;
		r.scalar_size = SIZE_DWORD;
		send_request(r);
		r = rand_request(ACT_FIND);            // size neither plain nor scalar
		r.tag = 16'h1234;
		r.scalar_size = 4'd3;
		send_request(r);
		r = rand_request(ACT_READ);
		r.address = 12'd0;
		send_request(r);
		r = rand_request(ACT_READ);            // far past the fill length
		r.address = 12'hfff;
		send_request(r);
		send_request(rand_request(ACT_CLEAR));

		// Random phases across capacity settings, extremes included.
		run_phase(13'h1fff, 160, 1'b0);
		run_phase(13'd0, 40, 1'b0);
		run_phase(13'd4, 40, 1'b0);
		run_phase(13'd40, 200, 1'b0);
		run_phase(13'($urandom_range(16, 160)), 200, 1'b0);
		run_phase(13'($urandom_range(0, 8191)), 200, 1'b0);
		run_phase(13'd4096, 100, 1'b1);

		drain();
		// the block is idle now; nothing may show up
		repeat (128) @(posedge clk);

		$display("Covered %0d requests over %0d capacity settings with random gaps and stalls.",
			book.requests, settings);
		$display("Finds that located a record: %0d, reads that returned a byte: %0d.",
			book.find_hits, book.read_hits);
		if (book.errors == 0 && book.replies_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: tlv_record_builder_walker.f
rtl/tlvb_pkg.sv
rtl/tlvb_store.sv
rtl/tlv_record_builder_walker.sv
rtl/tlvb_checker.sv
tb/sv/tlvb_book_pkg.sv
tb/sv/tb.sv
